// ===== src/adam_weight_update_assert.svh =====
// Assertion macros used by the checker of this block.
`ifndef ADAM_WEIGHT_UPDATE_ASSERT_SVH
`define ADAM_WEIGHT_UPDATE_ASSERT_SVH

// Check a property while out of reset.
`define AWU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define AWU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/awu_pkg.sv =====
package awu_pkg;

    localparam int FRAC_BITS = 24;
    localparam int ELEMENTS_DEFAULT = 4096;
    localparam int INDEX_W = 12;
    localparam logic [24:0] ONE_Q = 25'(1) << FRAC_BITS;
    localparam logic [31:0] U32MAX = 32'hFFFF_FFFF;

    localparam logic [24:0] LEARNING_RATE_RST = 25'd16777;
    localparam logic [23:0] GRADIENT_DECAY_RST = 24'd15099494;
    localparam logic [23:0] SQUARES_DECAY_RST = 24'd16760439;
    localparam logic [24:0] DAMPING_RST = 25'd1;
    localparam logic [24:0] BETA_ONE_SCALE_RST = 25'd16777216;

    typedef enum logic [2:0] {
        CFG_LEARNING_RATE  = 3'd0,
        CFG_GRADIENT_DECAY = 3'd1,
        CFG_SQUARES_DECAY  = 3'd2,
        CFG_DAMPING        = 3'd3,
        CFG_BETA_ONE_SCALE = 3'd4
    } awu_cfg_index_t;

    typedef struct packed {
        logic                first_of_pass;
        logic [INDEX_W-1:0]  element_index;
        logic signed [31:0]  gradient;
        logic signed [31:0]  weight_in;
    } awu_in_t;

    typedef struct packed {
        logic signed [31:0]  weight_out;
        logic [INDEX_W-1:0]  index_out;
    } awu_out_t;

    typedef struct packed {
        logic [24:0] learning_rate;
        logic [23:0] gradient_decay;
        logic [23:0] squares_decay;
        logic [24:0] damping;
        logic [24:0] beta_one_scale;
    } awu_cfg_t;

    typedef enum logic {
        KIND_ELEM = 1'b0,
        KIND_PASS = 1'b1
    } awu_kind_t;

    typedef struct packed {
        awu_kind_t           kind;
        logic [INDEX_W-1:0]  index;
        logic signed [31:0]  gradient;
        logic signed [31:0]  weight;
    } awu_entry_t;

    // Front to back: head of the queue.
    typedef struct packed {
        logic       avail;
        awu_entry_t entry;
    } awu_fq_t;

    // Back to front: pop and clearing status.
    typedef struct packed {
        logic pop;
        logic clearing;
    } awu_bk_t;

    // Floor shift of a non-negative product, limited to one.
    function automatic logic [24:0] cap_q(input logic [65:0] p);
        logic [65:0] t;
        t = p >> FRAC_BITS;
        return (t > 66'(ONE_Q)) ? ONE_Q : t[24:0];
    endfunction

endpackage

// ===== src/awu_front.sv =====
module awu_front
    import awu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  awu_in_t item,
    input  awu_bk_t bk,
    output awu_fq_t fq
);

    awu_entry_t entries_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    awu_entry_t entry;

    // Classify the word and take no item while the queue is full or during the clearing pass
    assign item_ready = (cnt_reg != 2'd2) && !bk.clearing;
    assign push = item_valid && item_ready;
    assign entry.kind = item.first_of_pass ? KIND_PASS : KIND_ELEM;
    assign entry.index = item.element_index;
    assign entry.gradient = item.gradient;
    assign entry.weight = item.weight_in;

    assign fq.avail = (cnt_reg != 2'd0);
    assign fq.entry = entries_reg[rd_ptr_reg];

    // Store into the queue
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= entry;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (bk.pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(bk.pop);
        end
    end

endmodule

// ===== src/awu_sqrt.sv =====
module awu_sqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] arg,
    output logic        busy,
    output logic [31:0] root
);

    logic [63:0] x_reg;
    logic [63:0] r_reg;
    logic [63:0] b_reg;
    logic [63:0] rb;

    assign busy = (b_reg != 64'd0);
    assign root = r_reg[31:0];
    assign rb = r_reg + b_reg;

    // Settle one root bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= 64'd0;
            r_reg <= 64'd0;
            b_reg <= 64'd0;
        end
        else if (start)
        begin
            x_reg <= arg;
            r_reg <= 64'd0;
            b_reg <= 64'd1 << 62;
        end
        else if (busy)
        begin
            if (x_reg >= rb)
            begin
                x_reg <= x_reg - rb;
                r_reg <= (r_reg >> 1) + b_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            b_reg <= b_reg >> 2;
        end
    end

endmodule

// ===== src/awu_div.sv =====
module awu_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [63:0] quot
);

    logic [31:0] div_reg;
    logic [31:0] rem_reg;
    logic [63:0] quo_reg;
    logic [6:0]  cnt_reg;
    logic [32:0] trial;
    logic        fits;

    assign busy = (cnt_reg != 7'd0);
    assign quot = quo_reg;
    assign trial = {rem_reg, quo_reg[63]};
    assign fits = (trial >= {1'b0, div_reg});

    // Restore one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg <= 32'd0;
            rem_reg <= 32'd0;
            quo_reg <= 64'd0;
            cnt_reg <= 7'd0;
        end
        else if (start)
        begin
            div_reg <= divisor;
            rem_reg <= 32'd0;
            quo_reg <= dividend;
            cnt_reg <= 7'd64;
        end
        else if (busy)
        begin
            rem_reg <= fits ? 32'(trial - {1'b0, div_reg}) : trial[31:0];
            quo_reg <= {quo_reg[62:0], fits};
            cnt_reg <= cnt_reg - 7'd1;
        end
    end

endmodule

// ===== src/awu_back.sv =====
module awu_back
    import awu_pkg::*;
#(
    parameter int ELEMENTS = ELEMENTS_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  awu_cfg_t cfg,
    input  awu_fq_t  fq,
    output awu_bk_t  bk,
    output logic     result_valid,
    input  logic     result_ready,
    output awu_out_t result
);

    localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
    localparam bit NEED_MOD = (ELEMENTS < (1 << INDEX_W));
    // Reciprocal of ELEMENTS, exact for every index of INDEX_W bits
    localparam int MOD_SHIFT = 2 * INDEX_W;
    localparam int MOD_RECIP = ((1 << MOD_SHIFT) + ELEMENTS - 1) / ELEMENTS;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE,
        S_P_STEP, S_P_DBO, S_P_BOP, S_P_BTP, S_P_SQ, S_P_NUM, S_P_DIV,
        S_E_SLOT, S_E_SLOTW, S_E_RD,
        S_E_M1, S_E_M2, S_E_M3, S_E_M4, S_E_M5, S_E_M6,
        S_E_SQ, S_E_Q, S_E_DIV, S_E_OUT
    } state_t;

    state_t state_reg;

    // Moment stores
    logic signed [31:0] fm_mem [ELEMENTS];
    logic [31:0]        sm_mem [ELEMENTS];
    logic signed [31:0] fm_q_reg;
    logic [31:0]        sm_q_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic [AW-1:0]      mem_addr;
    logic               fm_we;
    logic               sm_we;
    logic signed [31:0] fm_wd;
    logic [31:0]        sm_wd;

    // Pass state
    logic [31:0] step_count_reg;
    logic [24:0] dbo_reg;
    logic [24:0] bop_reg;
    logic [24:0] btp_reg;
    logic [31:0] step_rate_reg;

    // Element work registers
    logic [INDEX_W-1:0]  idx_reg;
    logic signed [31:0]  g_reg;
    logic signed [31:0]  w_reg;
    logic [AW-1:0]       slot_reg;
    logic [INDEX_W-1:0]  mod_q_reg;
    logic signed [65:0]  p_reg;
    logic signed [65:0]  acc_reg;
    logic signed [31:0]  m_reg;
    logic [31:0]         gsq_reg;
    logic [28:0]         den_reg;
    logic signed [31:0]  res_reg;
    logic                result_valid_reg;
    awu_out_t            result_reg;

    // Shared units
    logic signed [32:0] ma;
    logic signed [32:0] mb;
    logic               sq_start;
    logic [63:0]        sq_arg;
    logic               sq_busy;
    logic [31:0]        sq_root;
    logic               dv_start;
    logic [63:0]        dv_dividend;
    logic [31:0]        dv_divisor;
    logic               dv_busy;
    logic [63:0]        dv_quot;

    // Datapath helpers
    logic [24:0]        bt;
    logic [24:0]        btp_new;
    logic [24:0]        d_rate;
    logic signed [65:0] sum;
    logic signed [65:0] m_shift;
    logic signed [31:0] m_sat;
    logic [65:0]        v_shift;
    logic [31:0]        v_sat;
    logic [65:0]        gsq_shift;
    logic [31:0]        g_mag;
    logic [31:0]        m_mag;
    logic [28:0]        den_raw;
    logic [34:0]        q_cap;
    logic signed [36:0] w_ext;
    logic signed [36:0] res_wide;
    logic signed [31:0] res_sat;
    logic [36:0]        mod_prod;
    logic [INDEX_W-1:0] mod_rem;

    awu_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .arg   (sq_arg),
        .busy  (sq_busy),
        .root  (sq_root)
    );

    awu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .dividend (dv_dividend),
        .divisor  (dv_divisor),
        .busy     (dv_busy),
        .quot     (dv_quot)
    );

    assign bk.pop = (state_reg == S_IDLE) && fq.avail;
    assign bk.clearing = (state_reg == S_CLEAR);
    assign result_valid = result_valid_reg;
    assign result = result_reg;

    // Form the arithmetic of the current step
    always_comb
    begin
        bt = (dbo_reg > ONE_Q) ? ONE_Q : dbo_reg;
        btp_new = cap_q(p_reg);
        d_rate = ONE_Q - bop_reg;
        sum = acc_reg + p_reg;
        m_shift = sum >>> FRAC_BITS;
        if (m_shift > 66'sd2147483647)
        begin
            m_sat = 32'sh7FFF_FFFF;
        end
        else if (m_shift < -66'sd2147483648)
        begin
            m_sat = 32'sh8000_0000;
        end
        else
        begin
            m_sat = m_shift[31:0];
        end
        v_shift = $unsigned(sum) >> FRAC_BITS;
        v_sat = (v_shift > 66'(U32MAX)) ? U32MAX : v_shift[31:0];
        gsq_shift = $unsigned(p_reg) >> FRAC_BITS;
        g_mag = g_reg[31] ? 32'(-g_reg) : 32'(g_reg);
        m_mag = m_reg[31] ? 32'(-m_reg) : 32'(m_reg);
        den_raw = 29'(sq_root) + 29'(cfg.damping);
        q_cap = (dv_quot > 64'd17179869184) ? 35'd17179869184 : dv_quot[34:0];
        w_ext = 37'(w_reg);
        res_wide = m_reg[31] ? (w_ext + $signed({2'b00, q_cap}))
                             : (w_ext - $signed({2'b00, q_cap}));
        if (res_wide > 37'sd2147483647)
        begin
            res_sat = 32'sh7FFF_FFFF;
        end
        else if (res_wide < -37'sd2147483648)
        begin
            res_sat = 32'sh8000_0000;
        end
        else
        begin
            res_sat = res_wide[31:0];
        end
        mod_prod = 37'(idx_reg) * 37'(MOD_RECIP);
        mod_rem = idx_reg - INDEX_W'(mod_q_reg * INDEX_W'(ELEMENTS));
    end

    // Select multiplier, root and divider operands
    always_comb
    begin
        ma = 33'sd0;
        mb = 33'sd0;
        sq_start = 1'b0;
        sq_arg = 64'd0;
        dv_start = 1'b0;
        dv_dividend = 64'd0;
        dv_divisor = 32'd0;
        unique case (state_reg)
            S_P_STEP:
            begin
                ma = $signed({8'd0, dbo_reg});
                mb = $signed({8'd0, cfg.beta_one_scale});
            end
            S_P_DBO:
            begin
                ma = $signed({8'd0, bop_reg});
                mb = $signed({9'd0, cfg.gradient_decay});
            end
            S_P_BOP:
            begin
                ma = $signed({8'd0, btp_reg});
                mb = $signed({9'd0, cfg.squares_decay});
            end
            S_P_BTP:
            begin
                sq_start = 1'b1;
                sq_arg = 64'(ONE_Q - btp_new) << FRAC_BITS;
            end
            S_P_SQ:
            begin
                ma = $signed({8'd0, cfg.learning_rate});
                mb = $signed({1'b0, sq_root});
            end
            S_P_NUM:
            begin
                dv_start = (d_rate != 25'd0);
                dv_dividend = 64'(p_reg);
                dv_divisor = 32'(d_rate);
            end
            S_E_M1:
            begin
                ma = $signed({8'd0, bt});
                mb = 33'(fm_q_reg);
            end
            S_E_M2:
            begin
                ma = $signed({8'd0, ONE_Q - bt});
                mb = 33'(g_reg);
            end
            S_E_M3:
            begin
                ma = $signed({1'b0, g_mag});
                mb = $signed({1'b0, g_mag});
            end
            S_E_M4:
            begin
                ma = $signed({9'd0, cfg.squares_decay});
                mb = $signed({1'b0, sm_q_reg});
            end
            S_E_M5:
            begin
                ma = $signed({8'd0, ONE_Q - 25'(cfg.squares_decay)});
                mb = $signed({1'b0, gsq_reg});
            end
            S_E_M6:
            begin
                sq_start = 1'b1;
                sq_arg = 64'(v_sat) << FRAC_BITS;
            end
            S_E_SQ:
            begin
                ma = $signed({1'b0, step_rate_reg});
                mb = $signed({1'b0, m_mag});
            end
            S_E_Q:
            begin
                dv_start = 1'b1;
                dv_dividend = 64'(p_reg);
                dv_divisor = 32'(den_reg);
            end
            default:
            begin
            end
        endcase
    end

    // Drive the store write ports
    always_comb
    begin
        mem_addr = (state_reg == S_CLEAR) ? clr_cnt_reg : slot_reg;
        fm_we = (state_reg == S_CLEAR) || (state_reg == S_E_M3);
        sm_we = (state_reg == S_CLEAR) || (state_reg == S_E_M6);
        fm_wd = (state_reg == S_CLEAR) ? 32'sd0 : m_sat;
        sm_wd = (state_reg == S_CLEAR) ? 32'd0 : v_sat;
    end

    // Write and read the moment stores
    always_ff @(posedge clk)
    begin
        if (fm_we)
        begin
            fm_mem[mem_addr] <= fm_wd;
        end
        if (sm_we)
        begin
            sm_mem[mem_addr] <= sm_wd;
        end
        fm_q_reg <= fm_mem[slot_reg];
        sm_q_reg <= sm_mem[slot_reg];
    end

    // Form products
    always_ff @(posedge clk)
    begin
        p_reg <= ma * mb;
    end

    // Sequence the pass and element steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_cnt_reg <= '0;
            step_count_reg <= 32'd0;
            dbo_reg <= 25'd0;
            bop_reg <= ONE_Q;
            btp_reg <= ONE_Q;
            step_rate_reg <= 32'd0;
            idx_reg <= '0;
            g_reg <= 32'sd0;
            w_reg <= 32'sd0;
            slot_reg <= '0;
            mod_q_reg <= '0;
            acc_reg <= 66'sd0;
            m_reg <= 32'sd0;
            gsq_reg <= 32'd0;
            den_reg <= 29'd0;
            res_reg <= 32'sd0;
            result_valid_reg <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            // Drop a taken word unless the next one loads now
            if (result_valid_reg && result_ready && (state_reg != S_E_OUT))
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_cnt_reg == AW'(ELEMENTS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (fq.avail)
                    begin
                        idx_reg <= fq.entry.index;
                        g_reg <= fq.entry.gradient;
                        w_reg <= fq.entry.weight;
                        state_reg <= (fq.entry.kind == KIND_PASS) ? S_P_STEP : S_E_SLOT;
                    end
                end
                S_P_STEP:
                begin
                    if (step_count_reg != U32MAX)
                    begin
                        step_count_reg <= step_count_reg + 32'd1;
                    end
                    state_reg <= S_P_DBO;
                end
                S_P_DBO:
                begin
                    dbo_reg <= (step_count_reg == 32'd1) ? 25'(cfg.gradient_decay)
                                                         : cap_q(p_reg);
                    state_reg <= S_P_BOP;
                end
                S_P_BOP:
                begin
                    bop_reg <= cap_q(p_reg);
                    state_reg <= S_P_BTP;
                end
                S_P_BTP:
                begin
                    btp_reg <= btp_new;
                    state_reg <= S_P_SQ;
                end
                S_P_SQ:
                begin
                    if (!sq_busy)
                    begin
                        state_reg <= S_P_NUM;
                    end
                end
                S_P_NUM:
                begin
                    if (d_rate == 25'd0)
                    begin
                        step_rate_reg <= U32MAX;
                        state_reg <= S_E_SLOT;
                    end
                    else
                    begin
                        state_reg <= S_P_DIV;
                    end
                end
                S_P_DIV:
                begin
                    if (!dv_busy)
                    begin
                        step_rate_reg <= (dv_quot > 64'(U32MAX)) ? U32MAX : dv_quot[31:0];
                        state_reg <= S_E_SLOT;
                    end
                end
                S_E_SLOT:
                begin
                    if (NEED_MOD)
                    begin
                        mod_q_reg <= mod_prod[MOD_SHIFT +: INDEX_W];
                        state_reg <= S_E_SLOTW;
                    end
                    else
                    begin
                        slot_reg <= AW'(idx_reg);
                        state_reg <= S_E_RD;
                    end
                end
                S_E_SLOTW:
                begin
                    slot_reg <= AW'(mod_rem);
                    state_reg <= S_E_RD;
                end
                S_E_RD:
                begin
                    state_reg <= S_E_M1;
                end
                S_E_M1:
                begin
                    state_reg <= S_E_M2;
                end
                S_E_M2:
                begin
                    acc_reg <= p_reg;
                    state_reg <= S_E_M3;
                end
                S_E_M3:
                begin
                    m_reg <= m_sat;
                    state_reg <= S_E_M4;
                end
                S_E_M4:
                begin
                    gsq_reg <= (gsq_shift > 66'(U32MAX)) ? U32MAX : gsq_shift[31:0];
                    state_reg <= S_E_M5;
                end
                S_E_M5:
                begin
                    acc_reg <= p_reg;
                    state_reg <= S_E_M6;
                end
                S_E_M6:
                begin
                    state_reg <= S_E_SQ;
                end
                S_E_SQ:
                begin
                    if (!sq_busy)
                    begin
                        den_reg <= (den_raw == 29'd0) ? 29'd1 : den_raw;
                        state_reg <= S_E_Q;
                    end
                end
                S_E_Q:
                begin
                    state_reg <= S_E_DIV;
                end
                S_E_DIV:
                begin
                    if (!dv_busy)
                    begin
                        res_reg <= res_sat;
                        state_reg <= S_E_OUT;
                    end
                end
                S_E_OUT:
                begin
                    if (!result_valid_reg || result_ready)
                    begin
                        result_reg.weight_out <= res_reg;
                        result_reg.index_out <= idx_reg;
                        result_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/adam_weight_update.sv =====
// Adam weight update, fixed point with 24 fraction bits.
// Channels: item (valid/ready) carries one weight element with its gradient;
// result (valid/ready) returns the updated weight and its index, one word per
// item, in order. cfg (valid/ready, index and data) writes the five optimizer
// registers; it is always ready and must be used only while the block is idle.
// An item with first_of_pass set first advances the pass state and computes
// the step rate, then is handled as an element.
// An element runs its moment updates on a shared multiplier, then the
// bit-serial root and the restoring divider; a pass-start element first
// runs the root and, unless the rate divisor is zero, the divider for its
// step rate. With ELEMENTS below 4096 the store index passes through
// S_E_SLOTW for its reciprocal reduction. The back end takes one item at a
// time; a two-word queue keeps accepting meanwhile.
// Reset: the moment stores are zeroed by a clearing pass of ELEMENTS cycles,
// during which item_ready stays low; configuration writes are still taken.
// A stalled result holds in the output register and the back end waits; the
// queue then fills and item_ready drops.
module adam_weight_update
    import awu_pkg::*;
#(
    parameter int ELEMENTS = ELEMENTS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  awu_in_t     item,
    output logic        result_valid,
    input  logic        result_ready,
    output awu_out_t    result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [24:0] cfg_data
);

    awu_cfg_t cfg_reg;
    awu_fq_t  fq;
    awu_bk_t  bk;

    assign cfg_ready = 1'b1;

    // Write configuration registers; drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.learning_rate <= LEARNING_RATE_RST;
            cfg_reg.gradient_decay <= GRADIENT_DECAY_RST;
            cfg_reg.squares_decay <= SQUARES_DECAY_RST;
            cfg_reg.damping <= DAMPING_RST;
            cfg_reg.beta_one_scale <= BETA_ONE_SCALE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LEARNING_RATE:  cfg_reg.learning_rate <= cfg_data;
                CFG_GRADIENT_DECAY: cfg_reg.gradient_decay <= cfg_data[23:0];
                CFG_SQUARES_DECAY:  cfg_reg.squares_decay <= cfg_data[23:0];
                CFG_DAMPING:        cfg_reg.damping <= cfg_data;
                CFG_BETA_ONE_SCALE: cfg_reg.beta_one_scale <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    awu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .bk         (bk),
        .fq         (fq)
    );

    awu_back #(
        .ELEMENTS (ELEMENTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .fq           (fq),
        .bk           (bk),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== src/awu_checker.sv =====
`include "adam_weight_update_assert.svh"

module awu_checker
    import awu_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     item_valid,
    input logic     item_ready,
    input logic     result_valid,
    input logic     result_ready,
    input awu_out_t result
);

    // Stay quiet in reset
    `AWU_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> (!item_ready && !result_valid), "busy in reset")

    // Clear the stores before the first item
    `AWU_ASSERT_ALWAYS(a_clear_first, $rose(rst_n) |-> !item_ready, "item taken before clearing")

    // Hold a stalled result
    `AWU_ASSERT(a_result_hold, (result_valid && !result_ready) |=> (result_valid && $stable(result)), "result changed while stalled")

endmodule

bind adam_weight_update awu_checker u_awu_checker (.*);
